/* rtl/lci_pkg.sv */
// Package for the level crossing interpolator.
// Holds the sequencer state type and the multiplier chunk width; no dependencies.
package lci_pkg;

    localparam int MUL_CHUNK = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

/* rtl/level_crossing_interpolator_core.sv */
// Level crossing interpolator: top level with sequencer and shared multiply/divide datapath.
// Depends on lci_pkg.
//
// Takes curve points (position, value) in signed Q16.16 and keeps the previous point. When the
// two values lie on opposite sides of the crossing level (strict less-than), the block returns
// x0 + (x1 - x0) * (level - y0) / (y1 - y0), with the quotient truncated toward zero. Set
// first_point to start a new curve. A first point, or a point with no predecessor, is only
// stored as the previous point; any other point that gives no crossing returns to idle after
// the difference step. A point that crosses goes through the accept, the difference step, the
// product built 16 multiplier bits a cycle, the restoring divider settling one quotient bit a
// cycle, and the sum step. The input is stalled after the accept until the block is idle
// again. A finished result waits in an output register, so the next point is taken while it
// waits; if that register still holds an unaccepted beat, the sum step holds until it drains.
// Write crossing_level only while the block is idle.
module level_crossing_interpolator_core
    import lci_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DATA_WIDTH-1:0] i_cfg_crossing_level,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [DATA_WIDTH-1:0] i_x_position,
    input  logic [DATA_WIDTH-1:0] i_y_value,
    input  logic                  i_first_point,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DATA_WIDTH-1:0] o_crossing_x
);

    localparam int W         = DATA_WIDTH;
    localparam int MUL_STEPS = (W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int CW        = MUL_STEPS * MUL_CHUNK;
    localparam int AW        = W + CW;
    localparam int CNTW      = $clog2(W);

    t_state          r_state, n_state;
    logic [W-1:0]    r_level, n_level;
    logic [W-1:0]    r_prev_x, n_prev_x;
    logic [W-1:0]    r_prev_y, n_prev_y;
    logic            r_have_prev, n_have_prev;
    logic [W-1:0]    r_x1, n_x1;
    logic [W-1:0]    r_y1, n_y1;
    logic [W-1:0]    r_x0, n_x0;
    logic [W-1:0]    r_mdx, n_mdx;
    logic [W-1:0]    r_mden, n_mden;
    logic [CW-1:0]   r_mnum_sh, n_mnum_sh;
    logic [AW-1:0]   r_acc, n_acc;
    logic            r_neg, n_neg;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic [W-1:0]    r_out_x, n_out_x;

    logic [W:0]           d_dx, d_num, d_den;
    logic [W-1:0]         mdx, mnum, mden;
    logic                 crossing;
    logic [W+MUL_CHUNK-1:0] pp;
    logic [AW-1:0]        mul_next;
    logic [W:0]           div_t, div_r;
    logic                 div_ge;
    logic [W-1:0]         rem_new;
    logic [AW-1:0]        div_next;
    logic [W-1:0]         quot;
    logic [W-1:0]         result;

    // differences of the previous and the current point
    assign d_dx  = {r_x1[W-1], r_x1} - {r_prev_x[W-1], r_prev_x};
    assign d_num = {r_level[W-1], r_level} - {r_prev_y[W-1], r_prev_y};
    assign d_den = {r_y1[W-1], r_y1} - {r_prev_y[W-1], r_prev_y};
    assign mdx   = d_dx[W]  ? (~d_dx[W-1:0] + 1'b1)  : d_dx[W-1:0];
    assign mnum  = d_num[W] ? (~d_num[W-1:0] + 1'b1) : d_num[W-1:0];
    assign mden  = d_den[W] ? (~d_den[W-1:0] + 1'b1) : d_den[W-1:0];
    assign crossing = ($signed(r_prev_y) < $signed(r_level))
                   != ($signed(r_y1) < $signed(r_level));

    // shared multiplier step: one chunk of the numerator a cycle
    assign pp       = r_mdx * r_mnum_sh[CW-1 -: MUL_CHUNK];
    assign mul_next = {r_acc[AW-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + AW'(pp);

    // restoring divider step on the product held in the accumulator
    assign div_t    = {r_acc[2*W-1:W], r_acc[W-1]};
    assign div_r    = div_t - {1'b0, r_mden};
    assign div_ge   = div_t >= {1'b0, r_mden};
    assign rem_new  = div_ge ? div_r[W-1:0] : div_t[W-1:0];
    assign div_next = AW'({rem_new, r_acc[W-2:0], div_ge});

    assign quot   = r_acc[W-1:0];
    assign result = r_neg ? (r_x0 - quot) : (r_x0 + quot);

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_have_prev = r_have_prev;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_x0        = r_x0;
        n_mdx       = r_mdx;
        n_mden      = r_mden;
        n_mnum_sh   = r_mnum_sh;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;

        if (i_cfg_valid) begin
            n_level = i_cfg_crossing_level;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x1 = i_x_position;
                    n_y1 = i_y_value;
                    if (!i_first_point && r_have_prev) begin
                        n_state = S_PREP;
                    end else begin
                        n_prev_x    = i_x_position;
                        n_prev_y    = i_y_value;
                        n_have_prev = 1'b1;
                    end
                end
            end
            S_PREP: begin
                n_prev_x    = r_x1;
                n_prev_y    = r_y1;
                n_have_prev = 1'b1;
                n_x0        = r_prev_x;
                n_mdx       = mdx;
                n_mden      = mden;
                n_mnum_sh   = CW'(mnum);
                n_acc       = '0;
                n_neg       = (mnum != '0) && (d_dx[W] ^ d_num[W] ^ d_den[W]);
                n_cnt       = CNTW'(MUL_STEPS - 1);
                if (crossing && (mden != '0)) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_acc     = mul_next;
                n_mnum_sh = r_mnum_sh << MUL_CHUNK;
                if (r_cnt == '0) begin
                    n_cnt   = CNTW'(W - 1);
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIV: begin
                n_acc = div_next;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_x     = result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_x0      <= n_x0;
        r_mdx     <= n_mdx;
        r_mden    <= n_mden;
        r_mnum_sh <= n_mnum_sh;
        r_acc     <= n_acc;
        r_neg     <= n_neg;
        r_cnt     <= n_cnt;
        r_out_x   <= n_out_x;
    end

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_crossing_x = r_out_x;

    a_first_point_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_first_point) |=> (r_state == S_IDLE))
        else $error("first point started a computation");

    a_div_remainder_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_acc[2*W-1:W] < r_mden))
        else $error("divider remainder not below divisor");

    a_div_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_DONE))
        else $error("divider did not finish on count");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result beat not loaded from done state");

endmodule
